[sv/dtgs_pkg.sv]
// Package: types, constants and hash helpers for the tuple generation store.
package dtgs_pkg;

  localparam int unsigned DefStoreDepth = 1024;
  localparam int unsigned DefMaxArity   = 4;
  localparam int unsigned DefSymbolBits = 64;
  localparam int unsigned NumSyms       = 4;
  localparam int unsigned CountW        = 11;

  localparam logic [63:0] HashBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] HashPrime = 64'h00000100000001b3;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdSwap   = 2'd1;
  localparam logic [1:0] CmdCount  = 2'd2;

  localparam logic [0:0] RegArity = 1'b0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sym_0;
    logic [63:0] sym_1;
    logic [63:0] sym_2;
    logic [63:0] sym_3;
  } in_item_t;

  typedef struct packed {
    logic        added;
    logic        store_full;
    logic        new_round;
    logic [10:0] visible_count;
    logic [10:0] pending_count;
    logic [63:0] tuple_hash;
  } out_item_t;

  // h * prime as a shift-add: prime = 2^40 + 0x1b3
  function automatic logic [63:0] mul_prime(input logic [63:0] h);
    logic [63:0] r;
    r = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    return r;
  endfunction

endpackage

[sv/dtgs_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module dtgs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/dtgs_hash.sv]
// Iterative FNV-style hash unit: one multiply step per cycle.
module dtgs_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dtgs_pkg::NumSyms-1:0][63:0] syms_i,
  input  logic [2:0]                    arity_i,
  output logic                          done_o,
  output logic [63:0]                   hash_o
);
  import dtgs_pkg::*;

  logic [63:0] h_q, h_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        half_q, half_d;
  logic        run_q, run_d;
  logic [63:0] sym;

  assign sym    = syms_i[cnt_q[1:0]];
  assign hash_o = h_q;
  // done holds until the next start
  assign done_o = run_q && (cnt_q == arity_i);

  always_comb begin
    h_d = h_q; cnt_d = cnt_q; half_d = half_q; run_d = run_q;
    if (start_i) begin
      h_d = HashBasis; cnt_d = '0; half_d = 1'b0; run_d = 1'b1;
    end else if (run_q && cnt_q != arity_i) begin
      if (!half_q) begin
        h_d = mul_prime(h_q ^ sym);
      end else begin
        h_d = mul_prime(h_q ^ {32'd0, sym[63:32]});
        cnt_d = cnt_q + 3'd1;
      end
      half_d = !half_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; half_q <= 1'b0; run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; half_q <= half_d; run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end
endmodule

[sv/dedup_tuple_generation_store_core.sv]
// Top level: tuple store with generation counters, scan engine and APB register.
//
//  channel | dir | handshake            | payload
//  cmd     | in  | start / busy         | in_item_i
//  result  | out | res_valid_o (strobe) | res_item_o
//  config  | in  | APB psel/penable     | pwdata (tuple_arity)
//
// Insert: the scan does one memory read per stored entry, pipelined, then
// waits for the hash; a duplicate ends the scan early. Swap and count go from
// Idle straight to Done; the result strobe is registered from Done.
// busy drops in the strobe cycle. Reset clears counters and sets arity to 1;
// memory contents are not cleared. The result strobe lasts one cycle; the
// receiver cannot stall.
module dedup_tuple_generation_store_core #(
  parameter int unsigned StoreDepth = dtgs_pkg::DefStoreDepth,
  parameter int unsigned MaxArity   = dtgs_pkg::DefMaxArity,
  parameter int unsigned SymbolBits = dtgs_pkg::DefSymbolBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dtgs_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  output dtgs_pkg::out_item_t res_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dtgs_pkg::*;

  localparam int unsigned AW = $clog2(StoreDepth);
  localparam int unsigned CW = $clog2(StoreDepth + 1);
  localparam int unsigned MW = MaxArity * SymbolBits;
  localparam logic [63:0] SymMask = (SymbolBits >= 64) ? '1 : ((64'd1 << SymbolBits) - 64'd1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StScan  = 5'b00010,
    StDrain = 5'b00100,
    StWrite = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] arity_q;
  logic [CW-1:0] set_q, set_d, fr_q, fr_d, pen_q, pen_d, total;
  logic [CW-1:0] ridx_q, ridx_d;
  logic          cmp_q, cmp_d;
  logic          dup_q, dup_d;
  logic          added_q;
  in_item_t      item_q;
  logic [2:0]    eff;
  logic [NumSyms-1:0][63:0] syms;
  logic [MW-1:0] tup, rdata;
  logic          eq, we, hdone;
  logic [63:0]   hash;
  out_item_t     res_d, res_q;
  logic          rv_q, rv_d;

  assign pready = 1'b1;
  assign prdata = {29'd0, arity_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) arity_q <= 3'd1;
    else if (psel && penable && pwrite && paddr[1:0] == {RegArity, 1'b0}) arity_q <= pwdata[2:0];
  end

  always_comb begin
    eff = arity_q;
    if (eff == 3'd0) eff = 3'd1;
    if (eff > 3'(MaxArity)) eff = 3'(MaxArity);
  end

  always_comb begin
    syms[0] = item_q.sym_0; syms[1] = item_q.sym_1;
    syms[2] = item_q.sym_2; syms[3] = item_q.sym_3;
    for (int i = 0; i < NumSyms; i++) begin
      syms[i] = (3'(i) < eff) ? (syms[i] & SymMask) : '0;
    end
    for (int i = 0; i < MaxArity; i++) tup[i*SymbolBits +: SymbolBits] = syms[i][SymbolBits-1:0];
  end

  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < MaxArity; i++)
      if (3'(i) < eff && rdata[i*SymbolBits +: SymbolBits] != tup[i*SymbolBits +: SymbolBits])
        eq = 1'b0;
  end

  assign total = set_q + fr_q + pen_q;
  assign we    = (state_q == StWrite) && !dup_q && (total < CW'(StoreDepth));

  dtgs_ram #(.Width(MW), .Depth(StoreDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(total[AW-1:0]), .wdata_i(tup),
    .raddr_i(ridx_q[AW-1:0]), .rdata_o(rdata)
  );

  dtgs_hash u_hash (
    .clk_i, .rst_ni, .start_i(start && !busy && in_item_i.cmd == CmdInsert),
    .syms_i(syms), .arity_i(eff), .done_o(hdone), .hash_o(hash)
  );

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q; set_d = set_q; fr_d = fr_q; pen_d = pen_q;
    ridx_d = ridx_q; cmp_d = 1'b0; dup_d = dup_q; rv_d = 1'b0; res_d = res_q;
    case (state_q)
      StIdle: if (start) begin
        ridx_d = '0; dup_d = 1'b0;
        state_d = (in_item_i.cmd == CmdInsert) ? StScan : StDone;
      end
      StScan: begin
        if (cmp_q && eq) dup_d = 1'b1;
        if (ridx_q < total && ridx_q < CW'(StoreDepth) && !(dup_d)) begin
          cmp_d = 1'b1; ridx_d = ridx_q + CW'(1);
        end else state_d = StDrain;
      end
      StDrain: begin
        if (cmp_q && eq) dup_d = 1'b1;
        if (!cmp_q && hdone) state_d = StWrite;
      end
      StWrite: begin
        if (!dup_q && total < CW'(StoreDepth)) pen_d = pen_q + CW'(1);
        state_d = StDone;
      end
      StDone: begin
        res_d = '0;
        if (item_q.cmd == CmdInsert) begin
          res_d.added = added_q;
          res_d.store_full = !dup_q && !added_q;
          res_d.tuple_hash = hash;
        end else if (item_q.cmd == CmdSwap) begin
          set_d = set_q + fr_q; fr_d = pen_q; pen_d = '0;
          res_d.new_round = (pen_q != '0);
        end
        res_d.visible_count = 11'(set_d + fr_d);
        res_d.pending_count = 11'(pen_d);
        rv_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) added_q <= 1'b0;
    else if (state_q == StWrite) added_q <= we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; set_q <= '0; fr_q <= '0; pen_q <= '0;
      ridx_q <= '0; cmp_q <= 1'b0; dup_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; set_q <= set_d; fr_q <= fr_d; pen_q <= pen_d;
      ridx_q <= ridx_d; cmp_q <= cmp_d; dup_q <= dup_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start && !busy) item_q <= in_item_i;
  end

  assign res_valid_o = rv_q;
  assign res_item_o  = res_q;
endmodule

[sv/dtgs_checker.sv]
// Port-level checker for the tuple generation store, bound to the top level.
module dtgs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                res_valid_o,
  input dtgs_pkg::out_item_t res_item_o
);
  import dtgs_pkg::*;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after start");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_item_o.added && res_item_o.store_full))
    else $error("added and full together");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("strobe longer than one cycle");
  a_round_only_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_item_o.new_round |-> res_item_o.tuple_hash == '0 && !res_item_o.added)
    else $error("new_round with insert fields");
endmodule

bind dedup_tuple_generation_store_core dtgs_checker u_checker (
  .clk_i, .rst_ni, .start, .busy, .res_valid_o, .res_item_o
);

[tb/dedup_tuple_generation_store_core_tb.sv]
// Testbench for the deduplicating tuple generation store: directed table, then random phases.
module dedup_tuple_generation_store_core_tb;
  import dtgs_pkg::*;

  localparam int unsigned Depth     = 1024;
  localparam int unsigned CycleLimit = 4000000;
  localparam logic [1:0]  CmdNop    = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    in_item_i;
  logic        res_valid_o;
  out_item_t   res_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dedup_tuple_generation_store_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid_o),
    .res_item_o (res_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state
  logic [63:0] tuples [Depth][NumSyms];
  int unsigned settled_cnt, fresh_cnt, pending_cnt;
  logic [2:0]  arity_reg;
  out_item_t   expected_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          no_idle;

  function automatic logic [63:0] tuple_fnv(logic [63:0] t [NumSyms], int unsigned n);
    logic [63:0] h;
    h = HashBasis;
    for (int i = 0; i < n; i++) begin
      h = h ^ t[i];
      h = h * HashPrime;
      h = h ^ (t[i] >> 32);
      h = h * HashPrime;
    end
    return h;
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   r;
    logic [63:0] t [NumSyms];
    int unsigned n, total;
    bit          dup, eq;
    r = '0;
    if (it.cmd == CmdInsert) begin
      n = (arity_reg == 0) ? 1 : (arity_reg > NumSyms) ? NumSyms : arity_reg;
      t[0] = it.sym_0;
      t[1] = (n > 1) ? it.sym_1 : '0;
      t[2] = (n > 2) ? it.sym_2 : '0;
      t[3] = (n > 3) ? it.sym_3 : '0;
      r.tuple_hash = tuple_fnv(t, n);
      total = settled_cnt + fresh_cnt + pending_cnt;
      dup = 1'b0;
      for (int i = 0; i < total && !dup; i++) begin
        eq = 1'b1;
        for (int j = 0; j < n; j++) if (tuples[i][j] != t[j]) eq = 1'b0;
        dup = eq;
      end
      if (!dup) begin
        if (total >= Depth) begin
          r.store_full = 1'b1;
        end else begin
          for (int j = 0; j < NumSyms; j++) tuples[total][j] = t[j];
          pending_cnt++;
          r.added = 1'b1;
        end
      end
    end else if (it.cmd == CmdSwap) begin
      settled_cnt += fresh_cnt;
      fresh_cnt = pending_cnt;
      pending_cnt = 0;
      r.new_round = fresh_cnt > 0;
    end
    r.visible_count = 11'(settled_cnt + fresh_cnt);
    r.pending_count = 11'(pending_cnt);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_item_o);
      end else begin
        e = expected_results.pop_front();
        if (e.added !== res_item_o.added || e.store_full !== res_item_o.store_full ||
            e.new_round !== res_item_o.new_round ||
            e.visible_count !== res_item_o.visible_count ||
            e.pending_count !== res_item_o.pending_count ||
            e.tuple_hash !== res_item_o.tuple_hash) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: exp %p got %p", e, res_item_o);
        end
      end
    end
  end

  // drives one item and holds it until accepted; typed-in expectation wins if given
  task automatic send_item(in_item_t it, bit has_exp, out_item_t exp_r);
    out_item_t p;
    if (!no_idle && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start     <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (busy);
    p = apply_command(it);
    expected_results.push_back(has_exp ? exp_r : p);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_arity(logic [2:0] v);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {RegArity, 1'b0};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    arity_reg = v;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_sym();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return 64'($urandom_range(3));
    if (k < 70) begin
      case ($urandom_range(3))
        0: return '0;
        1: return '1;
        2: return 64'h8000_0000_0000_0000;
        default: return 64'hffff_ffff_0000_0000;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t rand_insert(bit full_rand);
    in_item_t    it;
    int unsigned total, idx;
    it.cmd = CmdInsert;
    total = settled_cnt + fresh_cnt + pending_cnt;
    if (full_rand) begin
      it.sym_0 = {$urandom, $urandom};
      it.sym_1 = {$urandom, $urandom};
      it.sym_2 = {$urandom, $urandom};
      it.sym_3 = {$urandom, $urandom};
    end else if (total > 0 && $urandom_range(99) < 20) begin
      idx = $urandom_range(total - 1);
      it.sym_0 = tuples[idx][0];
      it.sym_1 = tuples[idx][1];
      it.sym_2 = tuples[idx][2];
      it.sym_3 = tuples[idx][3];
    end else begin
      it.sym_0 = rand_sym();
      it.sym_1 = rand_sym();
      it.sym_2 = rand_sym();
      it.sym_3 = rand_sym();
    end
    return it;
  endfunction

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] s0, s1, s2, s3;
    bit          has_exp;
    out_item_t   exp_r;
  } row_t;

  row_t directed [] = '{
    '{CmdCount,  '0, '0, '0, '0, 1, '0},
    '{CmdSwap,   '0, '0, '0, '0, 1, '0},
    '{CmdNop,    '1, '1, '1, '1, 1, '0},
    '{CmdInsert, '0, '0, '0, '0, 0, '0},
    '{CmdInsert, '0, '1, '1, '1, 0, '0},
    '{CmdInsert, '1, '0, '0, '0, 0, '0},
    '{CmdInsert, 64'h8000_0000_0000_0000, '0, '0, '0, 0, '0},
    '{CmdInsert, 64'hffff_ffff_0000_0000, '0, '0, '0, 0, '0},
    '{CmdSwap,   '0, '0, '0, '0, 0, '0},
    '{CmdInsert, 64'h5, '0, '0, '0, 0, '0},
    '{CmdInsert, '1, '0, '0, '0, 0, '0},
    '{CmdCount,  '0, '0, '0, '0, 0, '0},
    '{CmdNop,    '0, '0, '0, '0, 0, '0},
    '{CmdSwap,   '0, '0, '0, '0, 0, '0},
    '{CmdSwap,   '0, '0, '0, '0, 0, '0},
    '{CmdInsert, 64'h0000_0000_ffff_ffff, '0, '0, '0, 0, '0},
    '{CmdSwap,   '0, '0, '0, '0, 0, '0}
  };

  logic [2:0] arity_plan [] = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd2};

  initial begin
    in_item_t    it;
    int unsigned k;
    rst_ni = 1'b0;
    start = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    settled_cnt = 0;
    fresh_cnt = 0;
    pending_cnt = 0;
    arity_reg = 3'd1;
    mismatches = 0;
    cycles = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[r]) begin
      it = '{directed[r].cmd, directed[r].s0, directed[r].s1, directed[r].s2, directed[r].s3};
      send_item(it, directed[r].has_exp, directed[r].exp_r);
    end

    foreach (arity_plan[p]) begin
      write_arity(arity_plan[p]);
      no_idle = (p == 3);
      for (int i = 0; i < 70; i++) begin
        k = $urandom_range(99);
        if (k < 70) it = rand_insert(1'b0);
        else begin
          it.sym_0 = {$urandom, $urandom};
          it.sym_1 = {$urandom, $urandom};
          it.sym_2 = {$urandom, $urandom};
          it.sym_3 = {$urandom, $urandom};
          it.cmd = (k < 82) ? CmdSwap : (k < 94) ? CmdCount : CmdNop;
        end
        send_item(it, 0, '0);
      end
    end
    no_idle = 1'b0;

    // new and repeated tuples at full arity
    write_arity(3'd4);
    for (int i = 0; i < 12; i++) send_item(rand_insert(1'(i % 2)), 0, '0);
    it = '0;
    it.cmd = CmdSwap;
    send_item(it, 0, '0);
    it.cmd = CmdCount;
    send_item(it, 0, '0);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[dedup_tuple_generation_store_core.f]
sv/dtgs_pkg.sv
sv/dtgs_ram.sv
sv/dtgs_hash.sv
sv/dedup_tuple_generation_store_core.sv
sv/dtgs_checker.sv
tb/dedup_tuple_generation_store_core_tb.sv
